/* hw/rtl/dksort_pkg.sv */
// dksort_pkg: shared types and constants for the descending key sorter
// no dependencies; imported by the controller, datapath and top level
package dksort_pkg;

    localparam int MAX_ITEMS_DEF = 16;
    localparam int KEY_W         = 24;
    localparam int TAG_W         = 8;

    typedef struct packed {
        logic [KEY_W-1:0] key_pt;
        logic [TAG_W-1:0] payload_tag;
        logic             is_final;
    } item_t;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_pt;
        logic [TAG_W-1:0] sorted_tag;
        logic             last_out;
        logic             overflow;
    } result_t;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic insert;
        logic mark_drop;
        logic shift;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic last_one;
    } status_t;

endpackage

/* hw/rtl/descending_key_sort_with_payload_top.sv */
// Stable descending sort of up to MAX_ITEMS key/tag items. While busy is low, every
// cycle with start high accepts one item, which is placed into sorted position in a
// register insertion chain in that same cycle. Items arriving with the store full are
// dropped and flag overflow. The item with is_final set closes the set: from the next
// cycle busy is high and the stored items, at most MAX_ITEMS, leave on consecutive
// cycles, largest key first, one per cycle with strobe high, shifted out of the head
// of the chain. The receiver cannot stall; a result is present only in the cycle its
// strobe is high.
// depends on dksort_pkg, dksort_ctrl, dksort_dpath
module descending_key_sort_with_payload_top #(
    parameter int MAX_ITEMS = dksort_pkg::MAX_ITEMS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  dksort_pkg::item_t   item,
    output logic                busy,
    output logic                strobe,
    output dksort_pkg::result_t result
);
    import dksort_pkg::*;

    cmd_t    cmd;
    status_t status;

    dksort_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .is_final (item.is_final),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .strobe   (strobe)
    );

    dksort_dpath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    a_final_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.is_final) |=> strobe)
        else $error("final item not followed by a result");

    a_emit_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last_out) |=> (strobe && (result.overflow == $past(result.overflow))))
        else $error("emission broke off or overflow changed mid set");

    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last_out) |=> (!busy && !result.overflow))
        else $error("block still busy or overflow kept after last result");

    a_descending: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last_out) |=> (result.sorted_pt <= $past(result.sorted_pt)))
        else $error("results out of descending order");

endmodule

/* hw/rtl/dksort_ctrl.sv */
// dksort_ctrl: load / emit controller for the descending key sorter
// depends on dksort_pkg (state_t, cmd_t, status_t)
module dksort_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               is_final,
    input  dksort_pkg::status_t status,
    output dksort_pkg::cmd_t    cmd,
    output logic               busy,
    output logic               strobe
);
    import dksort_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (start && is_final)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.last_one)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd    = '0;
        busy   = 1'b0;
        strobe = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                // a full store drops the item but a final one still ends the set
                cmd.insert    = start && !status.full;
                cmd.mark_drop = start && status.full;
            end
            ST_EMIT:
            begin
                busy      = 1'b1;
                strobe    = 1'b1;
                cmd.shift = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/dksort_dpath.sv */
// dksort_dpath: insertion chain of key/tag cells, fill count and overflow flag
// depends on dksort_pkg (item_t, result_t, cmd_t, status_t)
module dksort_dpath #(
    parameter int MAX_ITEMS = dksort_pkg::MAX_ITEMS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dksort_pkg::item_t   item,
    input  dksort_pkg::cmd_t    cmd,
    output dksort_pkg::status_t status,
    output dksort_pkg::result_t result
);
    import dksort_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [KEY_W-1:0] key_reg  [MAX_ITEMS];
    logic [KEY_W-1:0] key_next [MAX_ITEMS];
    logic [TAG_W-1:0] tag_reg  [MAX_ITEMS];
    logic [TAG_W-1:0] tag_next [MAX_ITEMS];
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic [MAX_ITEMS-1:0] keep;

    // stored cells are descending, so keep is a prefix mask
    // equal keys stay ahead of the new one, which keeps the sort stable
    always_comb
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            keep[i] = (CW'(i) < count_reg) && (key_reg[i] >= item.key_pt);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            key_next[i] = key_reg[i];
            tag_next[i] = tag_reg[i];
            if (cmd.insert)
            begin
                if (keep[i])
                begin
                    key_next[i] = key_reg[i];
                    tag_next[i] = tag_reg[i];
                end
                else if (i == 0)
                begin
                    key_next[i] = item.key_pt;
                    tag_next[i] = item.payload_tag;
                end
                else if (keep[(i == 0) ? 0 : i-1])
                begin
                    key_next[i] = item.key_pt;
                    tag_next[i] = item.payload_tag;
                end
                else
                begin
                    key_next[i] = key_reg[(i == 0) ? 0 : i-1];
                    tag_next[i] = tag_reg[(i == 0) ? 0 : i-1];
                end
            end
            else if (cmd.shift && (i < MAX_ITEMS - 1))
            begin
                // emit from cell 0, the rest move up one place
                key_next[i] = key_reg[(i < MAX_ITEMS - 1) ? i+1 : i];
                tag_next[i] = tag_reg[(i < MAX_ITEMS - 1) ? i+1 : i];
            end
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.shift)
        begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.mark_drop)
        begin
            overflow_next = 1'b1;
        end
        else if (cmd.shift && status.last_one)
        begin
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            key_reg[i] <= key_next[i];
            tag_reg[i] <= tag_next[i];
        end
    end

    assign status.full     = (count_reg == CW'(MAX_ITEMS));
    assign status.last_one = (count_reg == CW'(1));

    assign result.sorted_pt  = key_reg[0];
    assign result.sorted_tag = tag_reg[0];
    assign result.last_out   = status.last_one;
    assign result.overflow   = overflow_reg;

endmodule

/* tb/testbench.sv */
// testbench for descending_key_sort_with_payload_top: sends sets of key/tag items
// and checks each sorted stream against an internal insertion-sort predictor
// depends on dksort_pkg and descending_key_sort_with_payload_top
`timescale 1ns / 1ps

module testbench;
    import dksort_pkg::*;

    class sorted_stream_check;
        logic [KEY_W-1:0] key_store [MAX_ITEMS_DEF];
        logic [TAG_W-1:0] tag_store [MAX_ITEMS_DEF];
        int               stored;
        bit               dropped;
        result_t          ranked_q[$];
        int               errors;

        function new();
            stored  = 0;
            dropped = 1'b0;
            errors  = 0;
        endfunction

        // place the item behind every key that is not smaller, emit the set on final
        function void insert_item(item_t it);
            int pos;
            result_t r;
            if (stored < MAX_ITEMS_DEF)
            begin
                pos = stored;
                while (pos > 0 && key_store[pos-1] < it.key_pt)
                begin
                    key_store[pos] = key_store[pos-1];
                    tag_store[pos] = tag_store[pos-1];
                    pos--;
                end
                key_store[pos] = it.key_pt;
                tag_store[pos] = it.payload_tag;
                stored++;
            end
            else
            begin
                dropped = 1'b1;
            end
            if (it.is_final)
            begin
                for (int k = 0; k < stored; k++)
                begin
                    r.sorted_pt  = key_store[k];
                    r.sorted_tag = tag_store[k];
                    r.last_out   = (k + 1 == stored);
                    r.overflow   = dropped;
                    ranked_q     = {ranked_q, r};
                end
                stored  = 0;
                dropped = 1'b0;
            end
        endfunction

        function void check_rank(result_t got);
            result_t want;
            if (ranked_q.size() == 0)
            begin
                $error("unexpected result: sorted_pt %0d sorted_tag %0d", got.sorted_pt,
                       got.sorted_tag);
                errors++;
                return;
            end
            want = ranked_q.pop_front();
            if (got.sorted_pt !== want.sorted_pt)
            begin
                $error("sorted_pt: expected %0d, actual %0d", want.sorted_pt, got.sorted_pt);
                errors++;
            end
            if (got.sorted_tag !== want.sorted_tag)
            begin
                $error("sorted_tag: expected %0d, actual %0d", want.sorted_tag,
                       got.sorted_tag);
                errors++;
            end
            if (got.last_out !== want.last_out)
            begin
                $error("last_out: expected %0d, actual %0d", want.last_out, got.last_out);
                errors++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
                errors++;
            end
        endfunction

        function int pending();
            return ranked_q.size();
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 300;
    localparam int CYCLE_LIMIT  = 100000;

    logic    clk;
    logic    rst_n;
    logic    start;
    item_t   item;
    logic    busy;
    logic    strobe;
    result_t result;

    sorted_stream_check ranks;
    int                 cycles = 0;
    int                 sent;
    bit                 no_gaps;

    descending_key_sort_with_payload_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        ranks = new();
    end

    // inputs and outputs are sampled before this edge's updates land
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            ranks.insert_item(item);
        if (rst_n && strobe)
            ranks.check_rank(result);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("descending_key_sort_with_payload_top regression: fail");
            $finish;
        end
    end

    function automatic item_t make_item(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t, logic f);
        item_t it;
        it.key_pt      = k;
        it.payload_tag = t;
        it.is_final    = f;
        return it;
    endfunction

    // mix of full-range keys, tight clusters for ties, and both extremes
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0: return KEY_W'($urandom);
            1: return KEY_W'($urandom_range(0, 7));
            2: return $urandom_range(0, 1) ? {KEY_W{1'b1}} : '0;
            default: return {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 7));
        endcase
    endfunction

    // hold start with the item until accepted, then an optional idle gap
    task automatic send_item(item_t it);
        int gap;
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        sent++;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            item  <= make_item(KEY_W'($urandom), TAG_W'($urandom), 1'($urandom));
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_set(int len);
        for (int i = 0; i < len; i++)
            send_item(make_item(pick_key(), TAG_W'($urandom), i == len - 1));
    endtask

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        item    = '0;
        sent    = 0;
        no_gaps = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-item sets at both extremes
        send_item(make_item({KEY_W{1'b1}}, {TAG_W{1'b1}}, 1'b1));
        send_item(make_item('0, '0, 1'b1));
        // equal keys keep arrival order, larger key arriving late moves ahead
        send_item(make_item(24'd500, 8'd1, 1'b0));
        send_item(make_item(24'd500, 8'd2, 1'b0));
        send_item(make_item(24'd500, 8'd3, 1'b0));
        send_item(make_item(24'd900, 8'd4, 1'b0));
        send_item(make_item(24'd100, 8'd5, 1'b1));
        // store fills, then the final item itself is dropped
        no_gaps = 1'b1;
        for (int i = 0; i < MAX_ITEMS_DEF + 1; i++)
            send_item(make_item(24'(i * 3 % 7), 8'(i), i == MAX_ITEMS_DEF));
        no_gaps = 1'b0;

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: send_set($urandom_range(1, 6));
                6, 7:             send_set($urandom_range(7, MAX_ITEMS_DEF - 1));
                8:                send_set(MAX_ITEMS_DEF);
                default:          send_set($urandom_range(MAX_ITEMS_DEF + 1, MAX_ITEMS_DEF + 4));
            endcase
        end
        start <= 1'b0;

        while (ranks.pending() != 0)
            @(posedge clk);
        repeat (2 * MAX_ITEMS_DEF) @(posedge clk);

        if (ranks.pending() != 0)
        begin
            $error("%0d sorted results never arrived", ranks.pending());
            ranks.errors++;
        end
        if (ranks.errors == 0)
            $display("descending_key_sort_with_payload_top regression: pass");
        else
            $display("descending_key_sort_with_payload_top regression: fail");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/dksort_pkg.sv
hw/rtl/dksort_ctrl.sv
hw/rtl/dksort_dpath.sv
hw/rtl/descending_key_sort_with_payload_top.sv
tb/testbench.sv
